FILE: src/bslf_pkg.sv
// ----------------------------------------------------------------------------
// bslf_pkg
// Shared types, codes and defaults of the bitmap slot linked FIFO.
// ----------------------------------------------------------------------------
package bslf_pkg;

    localparam int SLOTS_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int MAX_PAYLOAD_W    = 64;
    localparam int ACTION_W         = 2;
    localparam int JOB_W            = 32;
    localparam int SLOT_PORT_W      = 6;
    localparam int STATUS_W         = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [JOB_W-1:0]       job_data;
        logic [SLOT_PORT_W-1:0] slot_in;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_PORT_W-1:0] slot_out;
        logic [JOB_W-1:0]       job_out;
    } t_out_item;

endpackage

FILE: src/bitmap_slot_linked_fifo_core.sv
// ----------------------------------------------------------------------------
// bitmap_slot_linked_fifo_core
// Job store of SLOTS slots, queued in arrival order through a linked list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one action
//   item: add a job, get the oldest waiting job, or finish a working slot.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result item per action, in order.
//   Add, finish and unknown actions: result is registered the cycle after
//   the item is taken; one item per cycle sustained while the receiver does not stall.
//   Get: the head slot's link and payload come from the memories through
//   their registered read ports, so a get passes through S_READ, where the
//   result is registered from the read data; no item is taken in S_READ.
//   The free slot is picked by a combinational priority encode of the
//   waiting/working masks, which live in flops; links and payloads live in
//   two RAMs.
//   A finished result sits in the output register; a new item is taken
//   while it waits only if the receiver is taking it in that same cycle.
//   Reset (synchronous, active low) empties the queue and clears all slot
//   marks. The RAMs are not cleared; entries are only read once written.
// ----------------------------------------------------------------------------
module bitmap_slot_linked_fifo_core
    import bslf_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int SLOT_W = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state,   n_state;
    logic [SLOTS-1:0]   r_waiting, n_waiting;
    logic [SLOTS-1:0]   r_working, n_working;
    logic [SLOT_W-1:0]  r_head,    n_head;
    logic [SLOT_W-1:0]  r_tail,    n_tail;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data,  n_out_data;

    logic               in_acc;
    logic               free_any;
    logic [SLOT_W-1:0]  free_idx;
    logic               link_we;
    logic               pay_we;
    logic               rd_en;
    logic [SLOT_W-1:0]  link_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [MAX_PAYLOAD_W-1:0] job_ext;
    logic [MAX_PAYLOAD_W-1:0] pay_ext;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign job_ext = MAX_PAYLOAD_W'(i_in_data.job_data);
    assign pay_ext = MAX_PAYLOAD_W'(pay_rd);

    bslf_prio_enc #(
        .N (SLOTS)
    ) u_prio (
        .i_req (~(r_waiting | r_working)),
        .o_any (free_any),
        .o_idx (free_idx)
    );

    bslf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (r_tail),
        .i_wr_data (free_idx),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (link_rd)
    );

    bslf_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOTS)
    ) u_pay_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pay_we),
        .i_wr_addr (free_idx),
        .i_wr_data (job_ext[PAYLOAD_BITS-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (pay_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_waiting   = r_waiting;
        n_working   = r_working;
        n_head      = r_head;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        link_we     = 1'b0;
        pay_we      = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data.status = ST_OK;
                    case (i_in_data.action)
                        ACT_ADD: begin
                            if (!free_any) begin
                                n_out_data.status = ST_FULL;
                            end else begin
                                pay_we = 1'b1;
                                // queue already holds a tail: link behind it
                                link_we = |r_waiting;
                                if (!(|r_waiting)) begin
                                    n_head = free_idx;
                                end
                                n_tail    = free_idx;
                                n_waiting = r_waiting | (SLOTS'(1) << free_idx);
                                n_out_data.slot_out = SLOT_PORT_W'(free_idx);
                            end
                        end
                        ACT_GET: begin
                            if (!(|r_waiting)) begin
                                n_out_data.status = ST_EMPTY;
                            end else begin
                                // result follows once the RAM data is back
                                n_out_valid = 1'b0;
                                rd_en       = 1'b1;
                                n_waiting   = r_waiting & ~(SLOTS'(1) << r_head);
                                n_working   = r_working | (SLOTS'(1) << r_head);
                                n_state     = S_READ;
                            end
                        end
                        ACT_FINISH: begin
                            if ({1'b0, i_in_data.slot_in} < (SLOT_PORT_W + 1)'(SLOTS)) begin
                                n_working = r_working
                                    & ~(SLOTS'(1) << i_in_data.slot_in[SLOT_W-1:0]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid         = 1'b1;
                n_out_data.status   = ST_OK;
                n_out_data.slot_out = SLOT_PORT_W'(r_head);
                n_out_data.job_out  = pay_ext[JOB_W-1:0];
                n_head              = link_rd;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_waiting   <= '0;
            r_working   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_waiting   <= n_waiting;
            r_working   <= n_working;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_waiting & r_working) == '0)
        else $error("slot marked both waiting and working");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy while get data returns");

    a_get_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.action == ACT_GET && (|r_waiting) |=> r_state == S_READ)
        else $error("get on a non-empty queue did not start a read");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_out_valid && r_out_data.status == ST_OK)
        else $error("get result not presented after read");

    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.action == ACT_ADD && !free_any
        |=> r_out_valid && r_out_data.status == ST_FULL && $stable(r_waiting))
        else $error("add on a full store mishandled");

endmodule

FILE: src/bslf_ram.sv
// ----------------------------------------------------------------------------
// bslf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bslf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: src/bslf_prio_enc.sv
// ----------------------------------------------------------------------------
// bslf_prio_enc
// Lowest-index-first priority encoder over the free-slot mask.
// ----------------------------------------------------------------------------
module bslf_prio_enc #(
    parameter int N = 64
) (
    input  logic [N-1:0]         i_req,
    output logic                 o_any,
    output logic [$clog2(N)-1:0] o_idx
);

    always_comb begin
        o_idx = '0;
        // scan downwards so the lowest set bit wins
        for (int i = N - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_idx = ($clog2(N))'(i);
            end
        end
    end

    assign o_any = |i_req;

endmodule
